### hdl/gmg_pkg.sv
// ----------------------------------------------------------------------------
// gmg_pkg
// Shared types, constants and helpers for the GNSS measurement gate.
// ----------------------------------------------------------------------------
package gmg_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned PosW  = 24;
    localparam int unsigned VelW  = 16;
    localparam int unsigned CfgW  = 20;
    localparam int unsigned AddrW = 5;

    // Clamp limits, held one bit wider than the stored position field
    localparam logic signed [PosW:0] PosLim = 25'sd8388607;
    localparam logic signed [PosW:0] VelLim = 25'sd32767;

    typedef enum logic [1:0] {
        CMD_FIX   = 2'd0,
        CMD_VEL   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_REF_VALID   = 3'd0;
    localparam logic [2:0] REG_FIX_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_VEL_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_STABLE_DUR  = 3'd3;
    localparam logic [2:0] REG_MAX_JUMP    = 3'd4;

    typedef struct packed {
        logic            reference_valid;
        logic [CfgW-1:0] fix_timeout;
        logic [CfgW-1:0] velocity_timeout;
        logic [CfgW-1:0] stable_duration;
        logic [CfgW-1:0] max_jump;
    } t_cfg;

    function automatic logic signed [PosW-1:0] clamp_pos(input logic signed [PosW:0] v);
        logic signed [PosW:0] r;
        begin
            if (v > PosLim) begin
                r = PosLim;
            end else if (v < -PosLim) begin
                r = -PosLim;
            end else begin
                r = v;
            end
            return r[PosW-1:0];
        end
    endfunction

    function automatic logic signed [VelW-1:0] clamp_vel(input logic signed [PosW:0] v);
        logic signed [PosW:0] r;
        begin
            if (v > VelLim) begin
                r = VelLim;
            end else if (v < -VelLim) begin
                r = -VelLim;
            end else begin
                r = v;
            end
            return r[VelW-1:0];
        end
    endfunction

    // now - last with a borrow bit on top: bit TimeW set means now < last
    function automatic logic [TimeW:0] time_diff(input logic [TimeW-1:0] now,
                                                 input logic [TimeW-1:0] last);
        return {1'b0, now} - {1'b0, last};
    endfunction

endpackage

### hdl/gnss_measurement_gate_unit.sv
// ----------------------------------------------------------------------------
// gnss_measurement_gate_unit
// Admission gate for ENU position fixes and velocity samples, stored as NED.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one transfer per command. tuser carries the
//   command (fix, velocity, query, clear); tdata carries the item time and
//   the east, north and up components.
//   Output stream (m_axis): exactly one result transfer per input transfer,
//   in order. tuser carries accepted / ready / estimate-valid flags, tdata
//   the stored NED position, NED velocity and the two sample times.
//   Configuration goes through the APB port. The user must write it only
//   while the block is idle; the block itself does not enforce this.
//   An item passes the input register, then the result register, before
//   o_m_axis_tvalid rises. One item per cycle is sustained while m_axis_tready
//   is high; the rate is set by the single pass that reads the measurement
//   state, runs the squared jump test and writes the state back.
// Reset:
//   Synchronous, active low. Clears the pipeline, all stored measurements
//   and loads the register defaults (no reference, 500 ms timeouts, 1000 ms
//   stability window, 500 cm jump limit).
// Stalls:
//   While m_axis_tready is low the result register holds; one more item is
//   taken into the input register, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module gnss_measurement_gate_unit
    import gmg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input stream
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: time_ms[31:0], coord_east[55:32], coord_north[79:56], coord_up[103:80]
    input  logic [103:0]     i_s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]       i_s_axis_tuser,
    // result stream
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // tdata: pos_north[23:0], pos_east[47:24], pos_down[71:48],
    //        vel_north[87:72], vel_east[103:88], vel_down[119:104],
    //        fix_time[151:120], vel_time[183:152]
    output logic [183:0]     o_m_axis_tdata,
    // tuser: accepted[0], ready_flag[1], estimate_valid[2]
    output logic [2:0]       o_m_axis_tuser,
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned AxN = 0;
    localparam int unsigned AxE = 1;
    localparam int unsigned AxD = 2;
    localparam int unsigned SqW = 2*PosW + 1;

    t_cfg cfg;

    gmg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Squared jump limit, refreshed every cycle from the register
    logic [2*CfgW-1:0] r_lim2;
    always_ff @(posedge i_clk) begin
        r_lim2 <= cfg.max_jump * cfg.max_jump;
    end

    // ---------------- input register ----------------
    logic                   r_in_valid;
    t_cmd                   r_in_cmd;
    logic [TimeW-1:0]       r_in_time;
    logic signed [PosW-1:0] r_in_e, r_in_n, r_in_u;

    logic advance, step;
    logic r_out_valid;

    // Result register empty or being drained this cycle
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cmd  <= t_cmd'(i_s_axis_tuser);
            r_in_time <= i_s_axis_tdata[31:0];
            r_in_e    <= i_s_axis_tdata[55:32];
            r_in_n    <= i_s_axis_tdata[79:56];
            r_in_u    <= i_s_axis_tdata[103:80];
        end
    end

    // ---------------- measurement state ----------------
    logic signed [PosW-1:0] r_pos [3];
    logic signed [VelW-1:0] r_vel [3];
    logic                   r_pos_present, r_vel_present;
    logic [TimeW-1:0]       r_last_fix, r_last_vel, r_fix_since, r_vel_since;

    logic signed [PosW-1:0] n_pos [3];
    logic signed [VelW-1:0] n_vel [3];
    logic                   n_pos_present, n_vel_present;
    logic [TimeW-1:0]       n_last_fix, n_last_vel, n_fix_since, n_vel_since;

    // ---------------- single-pass step ----------------
    logic signed [PosW:0]   in_n_x, in_e_x, in_d_x;
    logic signed [PosW-1:0] c_pn, c_pe, c_pd;
    logic signed [VelW-1:0] c_vn, c_ve, c_vd;
    logic [TimeW:0]         fix_dt, vel_dt, fix_now_dt, vel_now_dt, fs_dt, vs_dt;
    logic                   fix_stale, vel_stale;
    logic signed [PosW:0]   dn, de;
    logic signed [2*PosW+1:0] sq_n, sq_e;
    logic [SqW-1:0]         d2;
    logic                   jump_bad, fix_take, acc;
    logic                   fix_ok, vel_ok, ready;

    always_comb begin
        // ENU -> NED with clamping; negating the up component needs one extra bit
        in_n_x = {r_in_n[PosW-1], r_in_n};
        in_e_x = {r_in_e[PosW-1], r_in_e};
        in_d_x = -{r_in_u[PosW-1], r_in_u};
        c_pn   = clamp_pos(in_n_x);
        c_pe   = clamp_pos(in_e_x);
        c_pd   = clamp_pos(in_d_x);
        c_vn   = clamp_vel(in_n_x);
        c_ve   = clamp_vel(in_e_x);
        c_vd   = clamp_vel(in_d_x);

        fix_dt    = time_diff(r_in_time, r_last_fix);
        vel_dt    = time_diff(r_in_time, r_last_vel);
        fix_stale = r_pos_present && !fix_dt[TimeW] &&
                    (fix_dt[TimeW-1:0] > {{(TimeW-CfgW){1'b0}}, cfg.fix_timeout});
        vel_stale = r_vel_present && !vel_dt[TimeW] &&
                    (vel_dt[TimeW-1:0] > {{(TimeW-CfgW){1'b0}}, cfg.velocity_timeout});

        // Horizontal jump test on squared distances
        dn       = {c_pn[PosW-1], c_pn} - {r_pos[AxN][PosW-1], r_pos[AxN]};
        de       = {c_pe[PosW-1], c_pe} - {r_pos[AxE][PosW-1], r_pos[AxE]};
        sq_n     = dn * dn;
        sq_e     = de * de;
        d2       = sq_n[SqW-1:0] + sq_e[SqW-1:0];
        jump_bad = d2 > {{(SqW-2*CfgW){1'b0}}, r_lim2};
        fix_take = cfg.reference_valid && !(r_pos_present && !fix_stale && jump_bad);

        // Hold state by default
        n_pos         = r_pos;
        n_vel         = r_vel;
        n_pos_present = r_pos_present;
        n_vel_present = r_vel_present;
        n_last_fix    = r_last_fix;
        n_last_vel    = r_last_vel;
        n_fix_since   = r_fix_since;
        n_vel_since   = r_vel_since;
        acc           = 1'b1;

        case (r_in_cmd)
            CMD_FIX: begin
                acc = fix_take;
                if (fix_take) begin
                    // Restart the steady window on first, stale or backward fix
                    if (!r_pos_present || fix_stale || fix_dt[TimeW]) begin
                        n_fix_since = r_in_time;
                    end
                    n_pos[AxN]    = c_pn;
                    n_pos[AxE]    = c_pe;
                    n_pos[AxD]    = c_pd;
                    n_pos_present = 1'b1;
                    n_last_fix    = r_in_time;
                end
            end
            CMD_VEL: begin
                if (!r_vel_present || vel_stale || vel_dt[TimeW]) begin
                    n_vel_since = r_in_time;
                end
                n_vel[AxN]    = c_vn;
                n_vel[AxE]    = c_ve;
                n_vel[AxD]    = c_vd;
                n_vel_present = 1'b1;
                n_last_vel    = r_in_time;
            end
            CMD_QUERY: ;
            CMD_CLEAR: begin
                n_pos         = '{default: '0};
                n_vel         = '{default: '0};
                n_pos_present = 1'b0;
                n_vel_present = 1'b0;
                n_last_fix    = '0;
                n_last_vel    = '0;
                n_fix_since   = '0;
                n_vel_since   = '0;
            end
            default: ;
        endcase

        // Flags are judged on the state after this item
        fix_now_dt = time_diff(r_in_time, n_last_fix);
        vel_now_dt = time_diff(r_in_time, n_last_vel);
        fs_dt      = time_diff(r_in_time, n_fix_since);
        vs_dt      = time_diff(r_in_time, n_vel_since);
        fix_ok = n_pos_present && !fix_now_dt[TimeW] &&
                 (fix_now_dt[TimeW-1:0] <= {{(TimeW-CfgW){1'b0}}, cfg.fix_timeout});
        vel_ok = n_vel_present && !vel_now_dt[TimeW] &&
                 (vel_now_dt[TimeW-1:0] <= {{(TimeW-CfgW){1'b0}}, cfg.velocity_timeout});
        ready  = fix_ok && vel_ok && !fs_dt[TimeW] && !vs_dt[TimeW] &&
                 (fs_dt[TimeW-1:0] >= {{(TimeW-CfgW){1'b0}}, cfg.stable_duration}) &&
                 (vs_dt[TimeW-1:0] >= {{(TimeW-CfgW){1'b0}}, cfg.stable_duration});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '{default: '0};
            r_vel         <= '{default: '0};
            r_pos_present <= 1'b0;
            r_vel_present <= 1'b0;
            r_last_fix    <= '0;
            r_last_vel    <= '0;
            r_fix_since   <= '0;
            r_vel_since   <= '0;
        end else if (step) begin
            r_pos         <= n_pos;
            r_vel         <= n_vel;
            r_pos_present <= n_pos_present;
            r_vel_present <= n_vel_present;
            r_last_fix    <= n_last_fix;
            r_last_vel    <= n_last_vel;
            r_fix_since   <= n_fix_since;
            r_vel_since   <= n_vel_since;
        end
    end

    // ---------------- result register ----------------
    logic [183:0] r_out_tdata;
    logic [2:0]   r_out_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_tuser <= {fix_ok && vel_ok, ready, acc};
            r_out_tdata <= {n_last_vel, n_last_fix,
                            n_vel[AxD], n_vel[AxE], n_vel[AxN],
                            n_pos[AxD], n_pos[AxE], n_pos[AxN]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

    // ---------------- assertions ----------------
    // An absent position always reads as zero
    a_pos_zero_when_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pos_present |-> (r_pos[AxN] == '0 && r_pos[AxE] == '0 && r_pos[AxD] == '0))
        else $error("position store nonzero while no fix is present");

    // A fix is only taken in while a local reference is set
    a_fix_needs_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pos_present) |-> $past(cfg.reference_valid))
        else $error("fix stored without a local reference");

    // A stalled item in the input register is held, not dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_time)))
        else $error("input item lost while the result side stalled");

endmodule

### hdl/gmg_cfg_regs.sv
// ----------------------------------------------------------------------------
// gmg_cfg_regs
// APB register file holding the gate's reference flag, timeouts, stability window and jump limit.
// ----------------------------------------------------------------------------
module gmg_cfg_regs
    import gmg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[AddrW-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reference_valid  <= 1'b0;
            r_cfg.fix_timeout      <= CfgW'(500);
            r_cfg.velocity_timeout <= CfgW'(500);
            r_cfg.stable_duration  <= CfgW'(1000);
            r_cfg.max_jump         <= CfgW'(500);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_REF_VALID:   r_cfg.reference_valid  <= pwdata[0];
                REG_FIX_TIMEOUT: r_cfg.fix_timeout      <= pwdata[CfgW-1:0];
                REG_VEL_TIMEOUT: r_cfg.velocity_timeout <= pwdata[CfgW-1:0];
                REG_STABLE_DUR:  r_cfg.stable_duration  <= pwdata[CfgW-1:0];
                REG_MAX_JUMP:    r_cfg.max_jump         <= pwdata[CfgW-1:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_REF_VALID:   prdata = {31'b0, r_cfg.reference_valid};
            REG_FIX_TIMEOUT: prdata = {{(32-CfgW){1'b0}}, r_cfg.fix_timeout};
            REG_VEL_TIMEOUT: prdata = {{(32-CfgW){1'b0}}, r_cfg.velocity_timeout};
            REG_STABLE_DUR:  prdata = {{(32-CfgW){1'b0}}, r_cfg.stable_duration};
            REG_MAX_JUMP:    prdata = {{(32-CfgW){1'b0}}, r_cfg.max_jump};
            default:         prdata = 32'b0;
        endcase
    end

endmodule
